FILE: hw/rtl/cor_pkg.sv
// Shared constants and types for the circle octant rasterizer.
// No dependencies; every file of the block but the two interfaces imports this package.
package cor_pkg;

  // Default sizes of the centre coordinates and the radius.
  localparam int unsigned CoordBitsDef  = 12;
  localparam int unsigned RadiusBitsDef = 11;

  // Request codes.
  localparam logic ReqStart   = 1'b0;
  localparam logic ReqAdvance = 1'b1;

  // Eight mirrored pixels per step; one bit per beat index in the masks below.
  localparam int unsigned NumMirror = 8;
  localparam int unsigned IdxBits   = $clog2(NumMirror);

  // Beats 4..7 swap the x and y offsets.
  localparam logic [NumMirror-1:0] SwapMask   = 8'b1111_0000;
  // Beats 1, 2, 5, 6 subtract the column offset.
  localparam logic [NumMirror-1:0] NegColMask = 8'b0110_0110;
  // Beats 1, 3, 5, 7 subtract the row offset.
  localparam logic [NumMirror-1:0] NegRowMask = 8'b1010_1010;

  // Control of one group handed from the step unit to the emitter.
  typedef struct packed {
    logic vld;
    logic done;
  } grp_ctrl_t;

endpackage

FILE: hw/rtl/cor_req_if.sv
// Request channel of the circle octant rasterizer: valid/ready plus request payload.
// Depends on nothing; widths come from its parameters.
interface cor_req_if #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 11
);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius;

  modport source (output valid, req_type, center_x, center_y, radius, input ready);
  modport sink   (input valid, req_type, center_x, center_y, radius, output ready);
endinterface

FILE: hw/rtl/cor_pix_if.sv
// Pixel channel of the circle octant rasterizer: valid/ready plus pixel payload.
// Depends on nothing; widths come from its parameter.
interface cor_pix_if #(
  parameter int unsigned PIX_BITS = 14
);
  logic                       valid;
  logic                       ready;
  logic signed [PIX_BITS-1:0] pixel_x;
  logic signed [PIX_BITS-1:0] pixel_y;
  logic                       last_of_group;
  logic                       circle_done;

  modport source (output valid, pixel_x, pixel_y, last_of_group, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_group, circle_done, output ready);
endinterface

FILE: hw/rtl/cor_step.sv
// Step unit: request register, circle state and the midpoint decision update.
// Depends on cor_pkg and cor_req_if.
module cor_step import cor_pkg::*; #(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned RADIUS_BITS = RadiusBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  cor_req_if.sink                req_i,
  output grp_ctrl_t              grp_o,
  input  logic                   grp_rdy_i,
  output logic [COORD_BITS-1:0]  grp_cx_o,
  output logic [COORD_BITS-1:0]  grp_cy_o,
  output logic [RADIUS_BITS-1:0] grp_ox_o,
  output logic [RADIUS_BITS-1:0] grp_oy_o
);

  localparam int unsigned DecBits = RADIUS_BITS + 5;
  localparam int unsigned XBits   = RADIUS_BITS + 2;

  logic                   in_vld_q;
  logic                   in_type_q;
  logic [COORD_BITS-1:0]  in_cx_q, in_cy_q;
  logic [RADIUS_BITS-1:0] in_r_q;

  logic [RADIUS_BITS-1:0]    ox_q, oy_q;
  logic signed [DecBits-1:0] dec_q;
  logic [COORD_BITS-1:0]     ccol_q, crow_q;
  logic                      active_q;

  logic                      fire;
  logic                      is_start;
  logic signed [XBits-1:0]   x_s, y_s, diff_s;
  logic signed [DecBits-1:0] dec_adv, dec_start;
  logic                      adv_done;

  assign req_i.ready = !in_vld_q || grp_rdy_i;
  assign fire        = in_vld_q && grp_rdy_i;
  assign is_start    = (in_type_q == ReqStart);

  // Hold the request until the emitter takes its group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (grp_rdy_i) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_type_q <= req_i.req_type;
      in_cx_q   <= req_i.center_x;
      in_cy_q   <= req_i.center_y;
      in_r_q    <= req_i.radius;
    end
  end

  // Advance: x steps up, y steps down first when the decision is non-negative.
  always_comb begin
    x_s    = $signed({2'b00, ox_q}) + XBits'(1);
    y_s    = $signed({2'b00, oy_q});
    diff_s = '0;
    if (!dec_q[DecBits-1]) begin
      y_s     = y_s - XBits'(1);
      diff_s  = x_s - y_s;
      dec_adv = dec_q + (DecBits'(diff_s) <<< 2) + DecBits'(10);
    end else begin
      dec_adv = dec_q + (DecBits'(x_s) <<< 2) + DecBits'(6);
    end
    adv_done  = !active_q || (x_s > y_s);
    dec_start = DecBits'(3) - (DecBits'(in_r_q) <<< 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      dec_q    <= '0;
      ccol_q   <= '0;
      crow_q   <= '0;
      active_q <= 1'b0;
    end else if (fire) begin
      if (is_start) begin
        ccol_q   <= in_cx_q;
        crow_q   <= in_cy_q;
        ox_q     <= '0;
        oy_q     <= in_r_q;
        dec_q    <= dec_start;
        active_q <= 1'b1;
      end else if (active_q) begin
        if (adv_done) begin
          active_q <= 1'b0;
        end else begin
          ox_q  <= x_s[RADIUS_BITS-1:0];
          oy_q  <= y_s[RADIUS_BITS-1:0];
          dec_q <= dec_adv;
        end
      end
    end
  end

  assign grp_o.vld  = in_vld_q;
  assign grp_o.done = !is_start && adv_done;
  assign grp_cx_o   = is_start ? in_cx_q : ccol_q;
  assign grp_cy_o   = is_start ? in_cy_q : crow_q;
  assign grp_ox_o   = is_start ? '0 : x_s[RADIUS_BITS-1:0];
  assign grp_oy_o   = is_start ? in_r_q : y_s[RADIUS_BITS-1:0];

`ifndef SYNTHESIS
  a_octant_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ox_q <= oy_q)
    else $error("offset x passed offset y while a circle is active");
`endif

endmodule

FILE: hw/rtl/cor_emit.sv
// Emitter: holds one group and sends its eight mirrored pixels, or a done beat.
// Depends on cor_pkg and cor_pix_if.
module cor_emit import cor_pkg::*; #(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned RADIUS_BITS = RadiusBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  grp_ctrl_t              grp_i,
  output logic                   grp_rdy_o,
  input  logic [COORD_BITS-1:0]  grp_cx_i,
  input  logic [COORD_BITS-1:0]  grp_cy_i,
  input  logic [RADIUS_BITS-1:0] grp_ox_i,
  input  logic [RADIUS_BITS-1:0] grp_oy_i,
  cor_pix_if.source              pix_o
);

  localparam int unsigned PixBits = COORD_BITS + 2;

  logic                   slot_vld_q;
  logic                   slot_done_q;
  logic [IdxBits-1:0]     idx_q;
  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [RADIUS_BITS-1:0] ox_q, oy_q;

  logic                   take, load, last_beat;
  logic [RADIUS_BITS-1:0] off_col, off_row;
  logic [PixBits-1:0]     col_c, row_c, col_o, row_o;

  assign last_beat = slot_done_q || (idx_q == IdxBits'(NumMirror - 1));
  assign take      = slot_vld_q && pix_o.ready;
  assign grp_rdy_o = !slot_vld_q || (take && last_beat);
  assign load      = grp_i.vld && grp_rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      idx_q      <= '0;
    end else if (load) begin
      slot_vld_q <= 1'b1;
      idx_q      <= '0;
    end else if (take) begin
      if (last_beat) begin
        slot_vld_q <= 1'b0;
        idx_q      <= '0;
      end else begin
        idx_q <= idx_q + IdxBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_done_q <= grp_i.done;
      cx_q        <= grp_cx_i;
      cy_q        <= grp_cy_i;
      ox_q        <= grp_ox_i;
      oy_q        <= grp_oy_i;
    end
  end

  // Pick and sign the offsets for this beat's octant.
  always_comb begin
    off_col = SwapMask[idx_q] ? oy_q : ox_q;
    off_row = SwapMask[idx_q] ? ox_q : oy_q;
    col_c   = PixBits'(cx_q);
    row_c   = PixBits'(cy_q);
    col_o   = NegColMask[idx_q] ? col_c - PixBits'(off_col) : col_c + PixBits'(off_col);
    row_o   = NegRowMask[idx_q] ? row_c - PixBits'(off_row) : row_c + PixBits'(off_row);
  end

  assign pix_o.valid         = slot_vld_q;
  assign pix_o.pixel_x       = slot_done_q ? '0 : $signed(col_o);
  assign pix_o.pixel_y       = slot_done_q ? '0 : $signed(row_o);
  assign pix_o.last_of_group = last_beat;
  assign pix_o.circle_done   = slot_done_q;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.circle_done) |-> pix_o.last_of_group)
    else $error("done beat not marked last");

  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slot_vld_q |-> idx_q == '0)
    else $error("beat index not cleared while empty");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_beat && !grp_i.vld) |=> !slot_vld_q)
    else $error("slot still full after its last beat");
`endif

endmodule

FILE: hw/rtl/circle_octant_rasterizer.sv
// Top level of the circle octant rasterizer.
// Depends on cor_pkg, cor_req_if, cor_pix_if, cor_step and cor_emit.

// Midpoint circle rasterizer with eightfold symmetry. A start request (req_type 0)
// loads centre and radius and returns the eight mirrored pixels of offset (0, r);
// each advance request (req_type 1) moves one step along the octant and returns the
// next eight pixels, the eighth flagged last_of_group. Once the octant is finished,
// or when no circle is in progress, an advance returns one beat with circle_done and
// last_of_group set and zero coordinates. Pixels are two's complement, COORD_BITS+2
// wide, and may lie off screen. The emitter sends one pixel per beat from its group
// register; with a ready sink, the next group loads at the last beat of the current
// one, with no gap between groups. A request reaches the pixel channel through the
// request register, where the decision update is done, and then the emitter's group
// register. One further request is taken into the request register while the current
// group drains; after that the input stalls until the emitter takes the held
// request, at the last beat of the current group.
module circle_octant_rasterizer import cor_pkg::*; #(
  parameter int unsigned COORD_BITS  = CoordBitsDef,
  parameter int unsigned RADIUS_BITS = RadiusBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cor_req_if.sink   req_i,
  cor_pix_if.source pix_o
);

  // Group handed from the step unit to the emitter.
  grp_ctrl_t              grp;
  logic                   grp_rdy;
  logic [COORD_BITS-1:0]  grp_cx, grp_cy;
  logic [RADIUS_BITS-1:0] grp_ox, grp_oy;

  // Step unit: register the request, update offsets and decision, form the group.
  cor_step #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .grp_o     (grp),
    .grp_rdy_i (grp_rdy),
    .grp_cx_o  (grp_cx),
    .grp_cy_o  (grp_cy),
    .grp_ox_o  (grp_ox),
    .grp_oy_o  (grp_oy)
  );

  // Emitter: hold the group and send its mirrored pixels one beat at a time.
  cor_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .grp_i     (grp),
    .grp_rdy_o (grp_rdy),
    .grp_cx_i  (grp_cx),
    .grp_cy_i  (grp_cy),
    .grp_ox_i  (grp_ox),
    .grp_oy_i  (grp_oy),
    .pix_o     (pix_o)
  );

endmodule

FILE: test/circle_pixel_checker.sv
// Pixel checker for the circle octant rasterizer: watches both channels and predicts pixels.
// Depends on cor_pkg and the cor_req_if / cor_pix_if interfaces.
`timescale 1ns / 100ps

module circle_pixel_checker import cor_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cor_req_if          req_i,
  cor_pix_if          pix_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pixels_owed_o
);

  localparam int unsigned PixBits = CoordBitsDef + 2;
  localparam int unsigned DecBits = RadiusBitsDef + 5;

  typedef struct packed {
    logic signed [PixBits-1:0] px;
    logic signed [PixBits-1:0] py;
    logic                      last;
    logic                      done;
  } pix_beat_t;

  // Circle being traced.
  logic [CoordBitsDef-1:0]   circ_col_q;
  logic [CoordBitsDef-1:0]   circ_row_q;
  logic [RadiusBitsDef-1:0]  off_x_q;
  logic [RadiusBitsDef-1:0]  off_y_q;
  logic signed [DecBits-1:0] dec_q;
  logic                      tracing_q;

  pix_beat_t owed_pixels_q[$];
  pix_beat_t got_beat;
  pix_beat_t want_beat;
  int        cx, cy, sx, sy, sd;

  function automatic void owe_beat(int px, int py, logic last, logic done);
    pix_beat_t b;
    b.px   = px[PixBits-1:0];
    b.py   = py[PixBits-1:0];
    b.last = last;
    b.done = done;
    owed_pixels_q.push_back(b);
  endfunction

  // Eight mirrored pixels of the current offset pair, last one flagged.
  function automatic void owe_octants();
    int x, y;
    x = int'(off_x_q);
    y = int'(off_y_q);
    owe_beat(cx + x, cy + y, 1'b0, 1'b0);
    owe_beat(cx - x, cy - y, 1'b0, 1'b0);
    owe_beat(cx - x, cy + y, 1'b0, 1'b0);
    owe_beat(cx + x, cy - y, 1'b0, 1'b0);
    owe_beat(cx + y, cy + x, 1'b0, 1'b0);
    owe_beat(cx - y, cy - x, 1'b0, 1'b0);
    owe_beat(cx - y, cy + x, 1'b0, 1'b0);
    owe_beat(cx + y, cy - x, 1'b1, 1'b0);
  endfunction

  initial begin
    mismatch_cnt_o = 0;
    pixels_owed_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_col_q = '0;
      circ_row_q = '0;
      off_x_q    = '0;
      off_y_q    = '0;
      dec_q      = '0;
      tracing_q  = 1'b0;
      owed_pixels_q.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type == ReqStart) begin
          circ_col_q = req_i.center_x;
          circ_row_q = req_i.center_y;
          off_x_q    = '0;
          off_y_q    = req_i.radius;
          sd         = 3 - 2 * int'(req_i.radius);
          dec_q      = sd[DecBits-1:0];
          tracing_q  = 1'b1;
          cx         = int'(circ_col_q);
          cy         = int'(circ_row_q);
          owe_octants();
        end else if (!tracing_q) begin
          owe_beat(0, 0, 1'b1, 1'b1);
        end else begin
          sx = int'(off_x_q) + 1;
          sy = int'(off_y_q);
          sd = int'(dec_q);
          // When the decision is non-negative, step y down before the decision update.
          if (sd >= 0) begin
            sy = sy - 1;
            sd = sd + 4 * (sx - sy) + 10;
          end else begin
            sd = sd + 4 * sx + 6;
          end
          if (sx > sy) begin
            tracing_q = 1'b0;
            owe_beat(0, 0, 1'b1, 1'b1);
          end else begin
            off_x_q = sx[RadiusBitsDef-1:0];
            off_y_q = sy[RadiusBitsDef-1:0];
            dec_q   = sd[DecBits-1:0];
            cx      = int'(circ_col_q);
            cy      = int'(circ_row_q);
            owe_octants();
          end
        end
      end

      if (pix_i.valid && pix_i.ready) begin
        got_beat.px   = pix_i.pixel_x;
        got_beat.py   = pix_i.pixel_y;
        got_beat.last = pix_i.last_of_group;
        got_beat.done = pix_i.circle_done;
        if (owed_pixels_q.size() == 0) begin
          $error("pixel beat with no expected beat pending");
          mismatch_cnt_o++;
        end else begin
          want_beat = owed_pixels_q.pop_front();
          if (got_beat.px !== want_beat.px) begin
            $error("pixel_x: expected %0d, got %0d", want_beat.px, got_beat.px);
            mismatch_cnt_o++;
          end
          if (got_beat.py !== want_beat.py) begin
            $error("pixel_y: expected %0d, got %0d", want_beat.py, got_beat.py);
            mismatch_cnt_o++;
          end
          if (got_beat.last !== want_beat.last) begin
            $error("last_of_group: expected %0b, got %0b", want_beat.last, got_beat.last);
            mismatch_cnt_o++;
          end
          if (got_beat.done !== want_beat.done) begin
            $error("circle_done: expected %0b, got %0b", want_beat.done, got_beat.done);
            mismatch_cnt_o++;
          end
        end
      end
    end
    pixels_owed_o = owed_pixels_q.size();
  end

endmodule

FILE: test/tb_top.sv
// Top of the circle octant rasterizer testbench: clock, reset, request stimulus, verdict.
// Depends on cor_pkg, cor_req_if, cor_pix_if, circle_octant_rasterizer, circle_pixel_checker.
`timescale 1ns / 100ps

module tb_top;
  import cor_pkg::*;

  localparam int unsigned PixBits    = CoordBitsDef + 2;
  localparam int unsigned CoordMax   = (1 << CoordBitsDef) - 1;
  localparam int unsigned RadiusMax  = (1 << RadiusBitsDef) - 1;
  // Random requests after the directed part.
  localparam int unsigned RandItems  = 200;
  // Cycles the pixel sink holds ready low to back the block up.
  localparam int unsigned HoldCycles = 400;
  // Cycles allowed after the last beat for stray output.
  localparam int unsigned DrainWait  = 20;
  // Far above the slowest correct run, the hold included.
  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned mismatch_cnt;
  int unsigned pixels_owed;
  int unsigned cycle_cnt = 0;

  // Idle rates of both sides, in percent; the stimulus moves through the phases.
  int unsigned tx_idle_pct = 16;
  int unsigned rx_idle_pct = 53;
  int unsigned req_cnt     = 0;
  bit          hold_armed  = 1'b1;

  cor_req_if #(.COORD_BITS(CoordBitsDef), .RADIUS_BITS(RadiusBitsDef)) req_if ();
  cor_pix_if #(.PIX_BITS(PixBits)) pix_if ();

  circle_octant_rasterizer #(
    .COORD_BITS (CoordBitsDef),
    .RADIUS_BITS(RadiusBitsDef)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .pix_o (pix_if)
  );

  circle_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .pix_i         (pix_if),
    .mismatch_cnt_o(mismatch_cnt),
    .pixels_owed_o (pixels_owed)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bound the run: a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pixel sink. Drive one ready value per clock edge: either the long hold, or a random
  // stall at the current idle rate. The hold fires once the stream is well under way,
  // while the sender keeps offering requests, so the block fills and stalls its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    pix_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        pix_if.ready <= 1'b0;
      end else if (hold_armed && req_cnt >= 40) begin
        hold_armed = 1'b0;
        hold_left  = HoldCycles - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one request beat and hold it until accepted. Enter and leave on a rising edge;
  // valid gets at most one assignment per edge, so back-to-back beats keep it high.
  task automatic send_req(logic kind, int unsigned cx, int unsigned cy, int unsigned rad);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.center_x <= cx[CoordBitsDef-1:0];
    req_if.center_y <= cy[CoordBitsDef-1:0];
    req_if.radius   <= rad[RadiusBitsDef-1:0];
    do @(posedge clk_i); while (!req_if.ready);
    req_cnt++;
  endtask

  // Advance with noise in the ignored payload fields.
  task automatic step_circle();
    send_req(ReqAdvance, $urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
             $urandom_range(0, RadiusMax));
  endtask

  initial begin
    int unsigned rnd_start;
    int unsigned rad;
    int unsigned n_adv;
    int unsigned sel;

    rst_ni          = 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= ReqStart;
    req_if.center_x <= '0;
    req_if.center_y <= '0;
    req_if.radius   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // Advance before any circle: done beat, nothing traced.
    step_circle();
    // Radius zero at the origin: centre eight times, then done, then done while idle.
    send_req(ReqStart, 0, 0, 0);
    step_circle();
    step_circle();
    // Largest radius at the far corner: coordinates run past the screen.
    send_req(ReqStart, CoordMax, CoordMax, RadiusMax);
    repeat (3) step_circle();
    // Largest radius at column zero: negative columns.
    send_req(ReqStart, 0, CoordMax, RadiusMax);
    step_circle();
    // Radius one: the start group, then done at the first advance, then idle advances.
    send_req(ReqStart, 2048, 1, 1);
    repeat (3) step_circle();
    // Restart in mid-circle: drop the old one and finish the new one.
    send_req(ReqStart, 100, 200, 5);
    repeat (2) step_circle();
    send_req(ReqStart, CoordMax, 0, 3);
    repeat (5) step_circle();

    // Random part: mostly a start followed by enough advances to finish the octant;
    // some circles cut short by a new start, large radii always cut short, and a few
    // stray advances.
    rnd_start = req_cnt;
    while (req_cnt - rnd_start < RandItems) begin
      if (req_cnt - rnd_start < RandItems / 3) begin
        tx_idle_pct = 16;
        rx_idle_pct = 53;
      end else if (req_cnt - rnd_start < 2 * RandItems / 3) begin
        tx_idle_pct = 53;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        step_circle();
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 80) rad = $urandom_range(0, 15);
        else if (sel < 90) rad = $urandom_range(16, 60);
        else rad = $urandom_range(0, RadiusMax);
        send_req(ReqStart, $urandom_range(0, CoordMax), $urandom_range(0, CoordMax), rad);
        // The octant ends near x = r / sqrt(2); 3r/4 + 2 advances always reach done.
        if (rad <= 60 && $urandom_range(0, 3) != 0) n_adv = (rad * 3) / 4 + 2;
        else n_adv = $urandom_range(0, 6);
        repeat (n_adv) step_circle();
      end
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);

    // Drain: wait for every owed beat, then a little longer for stray output.
    while (pixels_owed != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: circle_octant_rasterizer.f
hw/rtl/cor_pkg.sv
hw/rtl/cor_req_if.sv
hw/rtl/cor_pix_if.sv
hw/rtl/cor_step.sv
hw/rtl/cor_emit.sv
hw/rtl/circle_octant_rasterizer.sv
test/circle_pixel_checker.sv
test/tb_top.sv
